/* rtl/core/crp_pkg.sv */
package crp_pkg;

   // field and datapath widths
   localparam int CRD_W  = 16;            // Q8.8 coordinate
   localparam int DIF_W  = CRD_W + 1;     // coordinate difference
   localparam int PRD_W  = 2 * DIF_W;     // difference product
   localparam int DOT_W  = PRD_W + 2;     // three-term dot product
   localparam int CRS_W  = PRD_W + 1;     // cross product component
   localparam int TRP_W  = 2 * CRS_W;     // triple product term
   localparam int TSUM_W = TRP_W + 2;     // triple product
   localparam int DIV_W  = TSUM_W + 2;    // divider operands
   localparam int FRAC_W = 16;            // ratio fraction bits
   localparam int QUO_W  = 31;            // quotient magnitude bits
   localparam int SAT_SH = QUO_W - FRAC_W;
   localparam int WT_W   = QUO_W + 3;     // barycentric weight
   localparam int MUL_W  = WT_W + CRD_W;  // weight times coordinate
   localparam int ACC_W  = MUL_W + 2;     // weighted sum
   localparam int RND_W  = ACC_W + 1;     // weighted sum plus half
   localparam int RGN_W  = 3;

   localparam logic [RGN_W-1:0] RGN_A    = 3'd0;
   localparam logic [RGN_W-1:0] RGN_B    = 3'd1;
   localparam logic [RGN_W-1:0] RGN_C    = 3'd2;
   localparam logic [RGN_W-1:0] RGN_AB   = 3'd3;
   localparam logic [RGN_W-1:0] RGN_BC   = 3'd4;
   localparam logic [RGN_W-1:0] RGN_CA   = 3'd5;
   localparam logic [RGN_W-1:0] RGN_FACE = 3'd6;

   localparam logic signed [WT_W-1:0]  ONE_WT   = WT_W'(65536);
   localparam logic signed [RND_W-1:0] HALF_RND = RND_W'(32768);
   localparam logic [QUO_W-1:0]        QUO_MAX  = '1;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // pipeline depths, accept edge to result strobe
   localparam int FRONT_STAGES = 5;
   localparam int QUEUE_STAGES = 1;
   localparam int DIV_STAGES   = QUO_W + 1;
   localparam int TAIL_STAGES  = 4;
   localparam int RSP_LATENCY  = FRONT_STAGES + QUEUE_STAGES + DIV_STAGES + TAIL_STAGES;

   typedef logic signed [CRD_W-1:0] crd_type;

   typedef struct packed {
      crd_type x;
      crd_type y;
      crd_type z;
   } point_type;

   typedef struct packed {
      point_type a;
      point_type b;
      point_type c;
   } verts_type;

   typedef struct packed {
      logic [RGN_W-1:0] region;
      logic             degen;
      verts_type        verts;
   } side_type;

   typedef struct packed {
      side_type                side;
      logic signed [DIV_W-1:0] num_u;
      logic signed [DIV_W-1:0] num_v;
      logic signed [DIV_W-1:0] den;
   } job_type;

   typedef struct packed {
      logic empty;
      logic full;
   } qstat_type;

   function automatic crd_type coord(input point_type p, input int k);
      case (k)
         0:       return p.x;
         1:       return p.y;
         default: return p.z;
      endcase
   endfunction

   function automatic int nxt3(input int k);
      return (k == 2) ? 0 : k + 1;
   endfunction

   function automatic int prv3(input int k);
      return (k == 0) ? 2 : k - 1;
   endfunction

endpackage

/* rtl/core/crp_front.sv */
module crp_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  crp_pkg::point_type  in_a,
   input  crp_pkg::point_type  in_b,
   input  crp_pkg::point_type  in_c,
   input  crp_pkg::point_type  in_p,
   output logic                push,
   output crp_pkg::job_type    job
);

   typedef logic signed [crp_pkg::DIF_W-1:0]  dif_type;
   typedef logic signed [crp_pkg::PRD_W-1:0]  prd_type;
   typedef logic signed [crp_pkg::DOT_W-1:0]  dot_type;
   typedef logic signed [crp_pkg::CRS_W-1:0]  crs_type;
   typedef logic signed [crp_pkg::TRP_W-1:0]  trp_type;
   typedef logic signed [crp_pkg::TSUM_W-1:0] tsum_type;
   typedef logic signed [crp_pkg::DIV_W-1:0]  div_type;

   logic [crp_pkg::FRONT_STAGES-1:0] vld_ff;
   crp_pkg::verts_type               verts_ff [crp_pkg::FRONT_STAGES];

   // stage 1: edge and offset vectors
   dif_type ab_ff [3], ac_ff [3], bc_ff [3], pa_ff [3], pb_ff [3], pc_ff [3];
   // stage 2: products
   prd_type dp_ff [6][3];
   prd_type cp_ff [4][3][2];
   // stage 3: dot and cross products
   dot_type dot3_ff [6];
   crs_type crs_ff  [4][3];
   // stage 4: triple product terms
   trp_type tp_ff   [3][3];
   dot_type dot4_ff [6];
   // stage 5: triple products
   tsum_type tsum_ff [3];
   dot_type  dot5_ff [6];

   dif_type dx [6][3], dy [6][3], cx [4][3], cy [4][3];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[crp_pkg::FRONT_STAGES-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      verts_ff[0] <= {in_a, in_b, in_c};
      for (int s = 1; s < crp_pkg::FRONT_STAGES; s++) begin
         verts_ff[s] <= verts_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         ab_ff[k] <= dif_type'(crp_pkg::coord(in_b, k)) - dif_type'(crp_pkg::coord(in_a, k));
         ac_ff[k] <= dif_type'(crp_pkg::coord(in_c, k)) - dif_type'(crp_pkg::coord(in_a, k));
         bc_ff[k] <= dif_type'(crp_pkg::coord(in_c, k)) - dif_type'(crp_pkg::coord(in_b, k));
         pa_ff[k] <= dif_type'(crp_pkg::coord(in_p, k)) - dif_type'(crp_pkg::coord(in_a, k));
         pb_ff[k] <= dif_type'(crp_pkg::coord(in_p, k)) - dif_type'(crp_pkg::coord(in_b, k));
         pc_ff[k] <= dif_type'(crp_pkg::coord(in_p, k)) - dif_type'(crp_pkg::coord(in_c, k));
      end
   end

   // dot operands: snom, tnom, sdenom, tdenom, unom, udenom
   // cross operands: normal, then (A-P)x(B-P) etc. (signs cancel)
   always_comb begin
      dx[0] = pa_ff; dy[0] = ab_ff;
      dx[1] = pa_ff; dy[1] = ac_ff;
      dx[2] = pb_ff; dy[2] = ab_ff;
      dx[3] = pc_ff; dy[3] = ac_ff;
      dx[4] = pb_ff; dy[4] = bc_ff;
      dx[5] = pc_ff; dy[5] = bc_ff;
      cx[0] = ab_ff; cy[0] = ac_ff;
      cx[1] = pa_ff; cy[1] = pb_ff;
      cx[2] = pb_ff; cy[2] = pc_ff;
      cx[3] = pc_ff; cy[3] = pa_ff;
   end

   always_ff @(posedge clock) begin
      for (int d = 0; d < 6; d++) begin
         for (int k = 0; k < 3; k++) begin
            dp_ff[d][k] <= prd_type'(dx[d][k]) * prd_type'(dy[d][k]);
         end
      end
      for (int j = 0; j < 4; j++) begin
         for (int k = 0; k < 3; k++) begin
            cp_ff[j][k][0] <= prd_type'(cx[j][crp_pkg::nxt3(k)]) *
                              prd_type'(cy[j][crp_pkg::prv3(k)]);
            cp_ff[j][k][1] <= prd_type'(cx[j][crp_pkg::prv3(k)]) *
                              prd_type'(cy[j][crp_pkg::nxt3(k)]);
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int d = 0; d < 6; d++) begin
         if (d == 2 || d == 3 || d == 5) begin
            dot3_ff[d] <= -(dot_type'(dp_ff[d][0]) + dot_type'(dp_ff[d][1]) +
                            dot_type'(dp_ff[d][2]));
         end else begin
            dot3_ff[d] <= dot_type'(dp_ff[d][0]) + dot_type'(dp_ff[d][1]) +
                          dot_type'(dp_ff[d][2]);
         end
      end
      for (int j = 0; j < 4; j++) begin
         for (int k = 0; k < 3; k++) begin
            crs_ff[j][k] <= crs_type'(cp_ff[j][k][0]) - crs_type'(cp_ff[j][k][1]);
         end
      end
   end

   always_ff @(posedge clock) begin
      dot4_ff <= dot3_ff;
      dot5_ff <= dot4_ff;
      for (int j = 0; j < 3; j++) begin
         for (int k = 0; k < 3; k++) begin
            tp_ff[j][k] <= trp_type'(crs_ff[0][k]) * trp_type'(crs_ff[j+1][k]);
         end
         tsum_ff[j] <= tsum_type'(tp_ff[j][0]) + tsum_type'(tp_ff[j][1]) +
                       tsum_type'(tp_ff[j][2]);
      end
   end

   // region selection
   dot_type  snom, tnom, sdn, tdn, unom, udn;
   tsum_type va, vb, vc;
   div_type  ab_sum, bc_sum, ca_sum, face_sum;

   assign snom = dot5_ff[0];
   assign tnom = dot5_ff[1];
   assign sdn  = dot5_ff[2];
   assign tdn  = dot5_ff[3];
   assign unom = dot5_ff[4];
   assign udn  = dot5_ff[5];
   assign vc   = tsum_ff[0];
   assign va   = tsum_ff[1];
   assign vb   = tsum_ff[2];

   assign ab_sum   = div_type'(snom) + div_type'(sdn);
   assign bc_sum   = div_type'(unom) + div_type'(udn);
   assign ca_sum   = div_type'(tnom) + div_type'(tdn);
   assign face_sum = div_type'(va) + div_type'(vb) + div_type'(vc);

   always_comb begin
      job.side.region = crp_pkg::RGN_FACE;
      job.side.degen  = 1'b0;
      job.side.verts  = verts_ff[crp_pkg::FRONT_STAGES-1];
      job.num_u       = '0;
      job.num_v       = '0;
      job.den         = div_type'(1);
      if (snom <= 0 && tnom <= 0) begin
         job.side.region = crp_pkg::RGN_A;
      end else if (sdn <= 0 && unom <= 0) begin
         job.side.region = crp_pkg::RGN_B;
      end else if (tdn <= 0 && udn <= 0) begin
         job.side.region = crp_pkg::RGN_C;
      end else if (vc <= 0 && snom >= 0 && sdn >= 0) begin
         job.side.region = crp_pkg::RGN_AB;
         if (ab_sum != 0) begin
            job.num_u = div_type'(snom);
            job.den   = ab_sum;
         end
      end else if (va <= 0 && unom >= 0 && udn >= 0) begin
         job.side.region = crp_pkg::RGN_BC;
         if (bc_sum != 0) begin
            job.num_u = div_type'(unom);
            job.den   = bc_sum;
         end
      end else if (vb <= 0 && tnom >= 0 && tdn >= 0) begin
         job.side.region = crp_pkg::RGN_CA;
         if (ca_sum != 0) begin
            job.num_u = div_type'(tnom);
            job.den   = ca_sum;
         end
      end else if (face_sum == 0) begin
         job.side.degen = 1'b1;
      end else begin
         job.num_u = div_type'(va);
         job.num_v = div_type'(vb);
         job.den   = face_sum;
      end
   end

   assign push = vld_ff[crp_pkg::FRONT_STAGES-1];

endmodule

/* rtl/core/crp_queue.sv */
module crp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  crp_pkg::job_type    job_in,
   input  logic                pop,
   output crp_pkg::job_type    job_out,
   output crp_pkg::qstat_type  stat
);

   crp_pkg::job_type          mem_ff [crp_pkg::QUEUE_DEPTH];
   logic [crp_pkg::QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [crp_pkg::QPTR_W:0]   cnt_ff, cnt_in;
   logic                       do_push, do_pop;

   assign stat.empty = (cnt_ff == '0);
   assign stat.full  = (cnt_ff == (crp_pkg::QPTR_W+1)'(crp_pkg::QUEUE_DEPTH));
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign job_out    = mem_ff[rd_ptr_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= job_in;
      end
   end

endmodule

/* rtl/core/crp_div.sv */
module crp_div (
   input  logic                            clock,
   input  logic signed [crp_pkg::DIV_W-1:0] num,
   input  logic signed [crp_pkg::DIV_W-1:0] den,
   output logic signed [crp_pkg::QUO_W:0]   quo
);

   // Q.16 quotient, truncated toward zero, magnitude saturated.
   // One restoring step per stage, QUO_W steps after the setup stage.
   logic [crp_pkg::DIV_W-1:0] rem_ff  [crp_pkg::QUO_W+1];
   logic [crp_pkg::DIV_W-1:0] dmag_ff [crp_pkg::QUO_W+1];
   logic [crp_pkg::QUO_W-1:0] nb_ff   [crp_pkg::QUO_W+1];
   logic [crp_pkg::QUO_W-1:0] q_ff    [crp_pkg::QUO_W+1];
   logic                      neg_ff  [crp_pkg::QUO_W+1];
   logic                      sat_ff  [crp_pkg::QUO_W+1];

   logic [crp_pkg::DIV_W-1:0] nmag_in, dmag_in;
   logic [crp_pkg::QUO_W-1:0] mag;

   assign nmag_in = num[crp_pkg::DIV_W-1] ? crp_pkg::DIV_W'(-num) : num;
   assign dmag_in = den[crp_pkg::DIV_W-1] ? crp_pkg::DIV_W'(-den) : den;

   always_ff @(posedge clock) begin
      rem_ff[0]  <= nmag_in >> crp_pkg::SAT_SH;
      dmag_ff[0] <= dmag_in;
      nb_ff[0]   <= {nmag_in[crp_pkg::SAT_SH-1:0], crp_pkg::FRAC_W'(0)};
      q_ff[0]    <= '0;
      neg_ff[0]  <= num[crp_pkg::DIV_W-1] ^ den[crp_pkg::DIV_W-1];
      sat_ff[0]  <= {crp_pkg::SAT_SH'(0), nmag_in} >= {dmag_in, crp_pkg::SAT_SH'(0)};
   end

   for (genvar s = 1; s <= crp_pkg::QUO_W; s++) begin : g_step
      logic [crp_pkg::DIV_W:0] raw, dif;
      logic                    ge;

      assign raw = {rem_ff[s-1], nb_ff[s-1][crp_pkg::QUO_W-1]};
      assign dif = raw - {1'b0, dmag_ff[s-1]};
      assign ge  = raw >= {1'b0, dmag_ff[s-1]};

      always_ff @(posedge clock) begin
         rem_ff[s]  <= ge ? dif[crp_pkg::DIV_W-1:0] : raw[crp_pkg::DIV_W-1:0];
         dmag_ff[s] <= dmag_ff[s-1];
         nb_ff[s]   <= nb_ff[s-1] << 1;
         q_ff[s]    <= {q_ff[s-1][crp_pkg::QUO_W-2:0], ge};
         neg_ff[s]  <= neg_ff[s-1];
         sat_ff[s]  <= sat_ff[s-1];
      end
   end

   assign mag = sat_ff[crp_pkg::QUO_W] ? crp_pkg::QUO_MAX : q_ff[crp_pkg::QUO_W];
   assign quo = neg_ff[crp_pkg::QUO_W] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

endmodule

/* rtl/core/crp_back.sv */
module crp_back (
   input  logic                         clock,
   input  logic                         reset,
   input  crp_pkg::qstat_type           qstat,
   input  crp_pkg::job_type             job,
   output logic                         pop,
   output logic                         rsp_valid,
   output logic signed [crp_pkg::CRD_W-1:0] rsp_nearest_x,
   output logic signed [crp_pkg::CRD_W-1:0] rsp_nearest_y,
   output logic signed [crp_pkg::CRD_W-1:0] rsp_nearest_z,
   output logic [crp_pkg::RGN_W-1:0]    rsp_region,
   output logic                         rsp_degenerate
);

   typedef logic signed [crp_pkg::WT_W-1:0]  wt_type;
   typedef logic signed [crp_pkg::MUL_W-1:0] mul_type;
   typedef logic signed [crp_pkg::ACC_W-1:0] acc_type;

   function automatic crp_pkg::crd_type round_sat(input acc_type s);
      logic signed [crp_pkg::RND_W-1:0]          t;
      logic signed [crp_pkg::RND_W-crp_pkg::FRAC_W-1:0] f;
      t = crp_pkg::RND_W'(s) + crp_pkg::HALF_RND;
      f = t[crp_pkg::RND_W-1:crp_pkg::FRAC_W];
      if (f > 32767) begin
         return 16'sh7FFF;
      end else if (f < -32768) begin
         return 16'sh8000;
      end else begin
         return f[crp_pkg::CRD_W-1:0];
      end
   endfunction

   logic signed [crp_pkg::QUO_W:0] quo_u, quo_v;

   logic              vld_ff  [crp_pkg::DIV_STAGES];
   crp_pkg::side_type side_ff [crp_pkg::DIV_STAGES];

   wt_type            wt_in [3], wt_ff [3];
   crp_pkg::side_type side_w_ff, side_m_ff, side_s_ff;
   logic              vld_w_ff, vld_m_ff, vld_s_ff, vld_o_ff;
   mul_type           mp_ff [3][3];
   acc_type           acc_ff [3];
   crp_pkg::crd_type  near_ff [3];
   logic [crp_pkg::RGN_W-1:0] region_ff;
   logic              degen_ff;
   crp_pkg::crd_type  cv [3][3];
   wt_type            r;

   assign pop = !qstat.empty;

   crp_div u_div_u (
      .clock (clock),
      .num   (job.num_u),
      .den   (job.den),
      .quo   (quo_u)
   );

   crp_div u_div_v (
      .clock (clock),
      .num   (job.num_v),
      .den   (job.den),
      .quo   (quo_v)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < crp_pkg::DIV_STAGES; s++) begin
            vld_ff[s] <= 1'b0;
         end
         vld_w_ff <= 1'b0;
         vld_m_ff <= 1'b0;
         vld_s_ff <= 1'b0;
         vld_o_ff <= 1'b0;
      end else begin
         vld_ff[0] <= pop;
         for (int s = 1; s < crp_pkg::DIV_STAGES; s++) begin
            vld_ff[s] <= vld_ff[s-1];
         end
         vld_w_ff <= vld_ff[crp_pkg::DIV_STAGES-1];
         vld_m_ff <= vld_w_ff;
         vld_s_ff <= vld_m_ff;
         vld_o_ff <= vld_s_ff;
      end
   end

   always_ff @(posedge clock) begin
      side_ff[0] <= job.side;
      for (int s = 1; s < crp_pkg::DIV_STAGES; s++) begin
         side_ff[s] <= side_ff[s-1];
      end
   end

   // every region reduces to wa*A + wb*B + wc*C in Q.16
   assign r = wt_type'(quo_u);

   always_comb begin
      wt_in[0] = '0;
      wt_in[1] = '0;
      wt_in[2] = '0;
      case (side_ff[crp_pkg::DIV_STAGES-1].region)
         crp_pkg::RGN_A: begin
            wt_in[0] = crp_pkg::ONE_WT;
         end
         crp_pkg::RGN_B: begin
            wt_in[1] = crp_pkg::ONE_WT;
         end
         crp_pkg::RGN_C: begin
            wt_in[2] = crp_pkg::ONE_WT;
         end
         crp_pkg::RGN_AB: begin
            wt_in[0] = crp_pkg::ONE_WT - r;
            wt_in[1] = r;
         end
         crp_pkg::RGN_BC: begin
            wt_in[1] = crp_pkg::ONE_WT - r;
            wt_in[2] = r;
         end
         crp_pkg::RGN_CA: begin
            wt_in[0] = crp_pkg::ONE_WT - r;
            wt_in[2] = r;
         end
         crp_pkg::RGN_FACE: begin
            if (side_ff[crp_pkg::DIV_STAGES-1].degen) begin
               wt_in[0] = crp_pkg::ONE_WT;
            end else begin
               wt_in[0] = r;
               wt_in[1] = wt_type'(quo_v);
               wt_in[2] = crp_pkg::ONE_WT - r - wt_type'(quo_v);
            end
         end
         default: begin
            wt_in[0] = '0;
         end
      endcase
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         cv[0][k] = crp_pkg::coord(side_w_ff.verts.a, k);
         cv[1][k] = crp_pkg::coord(side_w_ff.verts.b, k);
         cv[2][k] = crp_pkg::coord(side_w_ff.verts.c, k);
      end
   end

   always_ff @(posedge clock) begin
      wt_ff     <= wt_in;
      side_w_ff <= side_ff[crp_pkg::DIV_STAGES-1];
      side_m_ff <= side_w_ff;
      side_s_ff <= side_m_ff;
      for (int j = 0; j < 3; j++) begin
         for (int k = 0; k < 3; k++) begin
            mp_ff[j][k] <= mul_type'(wt_ff[j]) * mul_type'(cv[j][k]);
         end
      end
      for (int k = 0; k < 3; k++) begin
         acc_ff[k]  <= acc_type'(mp_ff[0][k]) + acc_type'(mp_ff[1][k]) +
                       acc_type'(mp_ff[2][k]);
         near_ff[k] <= round_sat(acc_ff[k]);
      end
      region_ff <= side_s_ff.region;
      degen_ff  <= side_s_ff.degen;
   end

   assign rsp_valid      = vld_o_ff;
   assign rsp_nearest_x  = near_ff[0];
   assign rsp_nearest_y  = near_ff[1];
   assign rsp_nearest_z  = near_ff[2];
   assign rsp_region     = region_ff;
   assign rsp_degenerate = degen_ff;

endmodule

/* rtl/core/closest_point_on_triangle_unit.sv */
// Closest point on a triangle to a query point, Voronoi region method.
// Request: triangle vertices A, B, C and query point P, all signed Q8.8.
//   A request is taken at a rising edge with start high and busy low.
// Response: nearest point (Q8.8, rounded to nearest, saturated), the region
//   code (vertex A/B/C, edge AB/BC/CA, face) and a degenerate flag for a
//   zero face denominator (vertex A returned). rsp_valid is high for exactly
//   one cycle per request; the result is taken at the edge that ends it.
// Throughput: one request per cycle while busy is low, fully pipelined.
// Pipeline: from the accept edge to the edge that samples rsp_valid, a
//   request passes 5 front stages (edge vectors, products, dot/cross sums,
//   triple product terms, triple products), 1 queue stage, 32 divider
//   stages (setup plus one restoring quotient bit per stage for the 31-bit
//   Q.16 ratio) and 4 tail stages (weights, products, sums, round/saturate).
// The front classifies each request and hands it to the back through a
//   4-entry queue; the back drains one entry per cycle, so busy stays low
//   in normal running and only rises if the queue fills.
// Reset: synchronous, active high; clears all pipeline valids and the
//   queue, in-flight requests are dropped. No clearing pass, no registers.
// The response side has no back-pressure: results are never held.
module closest_point_on_triangle_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic signed [crp_pkg::CRD_W-1:0]  req_vertex_a_x,
   input  logic signed [crp_pkg::CRD_W-1:0]  req_vertex_a_y,
   input  logic signed [crp_pkg::CRD_W-1:0]  req_vertex_a_z,
   input  logic signed [crp_pkg::CRD_W-1:0]  req_vertex_b_x,
   input  logic signed [crp_pkg::CRD_W-1:0]  req_vertex_b_y,
   input  logic signed [crp_pkg::CRD_W-1:0]  req_vertex_b_z,
   input  logic signed [crp_pkg::CRD_W-1:0]  req_vertex_c_x,
   input  logic signed [crp_pkg::CRD_W-1:0]  req_vertex_c_y,
   input  logic signed [crp_pkg::CRD_W-1:0]  req_vertex_c_z,
   input  logic signed [crp_pkg::CRD_W-1:0]  req_query_x,
   input  logic signed [crp_pkg::CRD_W-1:0]  req_query_y,
   input  logic signed [crp_pkg::CRD_W-1:0]  req_query_z,
   output logic                              rsp_valid,
   output logic signed [crp_pkg::CRD_W-1:0]  rsp_nearest_x,
   output logic signed [crp_pkg::CRD_W-1:0]  rsp_nearest_y,
   output logic signed [crp_pkg::CRD_W-1:0]  rsp_nearest_z,
   output logic [crp_pkg::RGN_W-1:0]         rsp_region,
   output logic                              rsp_degenerate
);

   crp_pkg::point_type  pt_a, pt_b, pt_c, pt_p;
   crp_pkg::job_type    front_job, queue_job;
   crp_pkg::qstat_type  qstat;
   logic                accept;
   logic                push;
   logic                pop;

   // accept when the queue can still take the request
   assign busy   = qstat.full;
   assign accept = start && !busy;

   assign pt_a = {req_vertex_a_x, req_vertex_a_y, req_vertex_a_z};
   assign pt_b = {req_vertex_b_x, req_vertex_b_y, req_vertex_b_z};
   assign pt_c = {req_vertex_c_x, req_vertex_c_y, req_vertex_c_z};
   assign pt_p = {req_query_x, req_query_y, req_query_z};

   // front: dot, cross and triple products, region pick, divider operands
   crp_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .in_a     (pt_a),
      .in_b     (pt_b),
      .in_c     (pt_c),
      .in_p     (pt_p),
      .push     (push),
      .job      (front_job)
   );

   crp_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .job_in  (front_job),
      .pop     (pop),
      .job_out (queue_job),
      .stat    (qstat)
   );

   // back: ratio dividers, weighted vertex sum, rounding
   crp_back u_back (
      .clock          (clock),
      .reset          (reset),
      .qstat          (qstat),
      .job            (queue_job),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_nearest_x  (rsp_nearest_x),
      .rsp_nearest_y  (rsp_nearest_y),
      .rsp_nearest_z  (rsp_nearest_z),
      .rsp_region     (rsp_region),
      .rsp_degenerate (rsp_degenerate)
   );

endmodule

/* rtl/core/crp_checker.sv */
module crp_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      start,
   input logic                      busy,
   input logic                      rsp_valid,
   input logic [crp_pkg::RGN_W-1:0] rsp_region,
   input logic                      rsp_degenerate
);

   // every response traces back to a request a fixed latency earlier
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, crp_pkg::RSP_LATENCY))
      else $error("response without matching request");

   a_region: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_region <= crp_pkg::RGN_FACE))
      else $error("region code out of range");

   a_degen: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_degenerate) |-> (rsp_region == crp_pkg::RGN_FACE))
      else $error("degenerate flag outside face region");

endmodule

bind closest_point_on_triangle_unit crp_checker u_crp_checker (.*);
